// File: sv/rcs_pkg.sv
// shared types and constants for the raycast column setup pipeline
`default_nettype none
package rcs_pkg;

  // reciprocal unit: 2^28 / m, 24 quotient bits, four bits per stage
  localparam int Q_BITS         = 24;
  localparam int BITS_PER_STAGE = 4;
  localparam int DIV_STAGES     = Q_BITS / BITS_PER_STAGE;
  // dividend bits above the quotient field, 2^28 >> 24
  localparam logic [16:0] REM_INIT = 17'd16;
  // divisors up to this value give a quotient beyond 24 bits
  localparam logic [16:0] SAT_LIMIT = 17'd16;

  localparam logic [23:0] ONE_Q14   = 24'd16384;
  localparam logic [23:0] DELTA_MAX = 24'hFFFFFF;

  // stages from accept to result, camera x (4) + ray (2) + divider + delta, side, output (3)
  localparam int PIPE_LATENCY = 4 + 2 + DIV_STAGES + 3;

  typedef enum logic [2:0] {
    REG_PLAYER_X    = 3'd0,
    REG_PLAYER_Y    = 3'd1,
    REG_VIEW_DIR_X  = 3'd2,
    REG_VIEW_DIR_Y  = 3'd3,
    REG_CAM_PLANE_X = 3'd4,
    REG_CAM_PLANE_Y = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic               valid;
    logic signed [15:0] camx;
  } cam_t;

  typedef struct packed {
    logic               valid;
    logic signed [16:0] ray_x;
    logic signed [16:0] ray_y;
  } ray_t;

endpackage
`default_nettype wire

// File: sv/raycast_column_setup_top.sv
// Ray setup for one screen column: camera x, ray direction, start cell, step signs,
// delta and initial side distances. A column is taken on every clock cycle in which
// start is high and busy is low; busy is high only during reset. The result appears
// on out_strobe once the column has passed through the camera x
// stages (4), the ray stages (2), the 2^28/|ray| divider (6 stages, four quotient
// bits each) and the delta, side and output stages (3). Results cannot be held off,
// and any number of columns may be in flight. Configuration writes are always ready
// and must only be made while no column is in flight.
`default_nettype none
module raycast_column_setup_top #(
  parameter int SCREEN_WIDTH = 640
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [11:0]        in_column,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [21:0]        cfg_data,
  output logic                    out_strobe,
  output logic signed [16:0]      out_ray_x,
  output logic signed [16:0]      out_ray_y,
  output logic [5:0]              out_cell_x,
  output logic [5:0]              out_cell_y,
  output logic                    out_step_x_neg,
  output logic                    out_step_y_neg,
  output logic [23:0]             out_delta_x,
  output logic [23:0]             out_delta_y,
  output logic [23:0]             out_side_x,
  output logic [23:0]             out_side_y
);
  import rcs_pkg::*;

  logic [21:0]        player_x_r, player_y_r;
  logic signed [15:0] dir_x_r, dir_y_r, pln_x_r, pln_y_r;

  cam_t               cam;
  logic               v5_r;
  logic signed [31:0] prod_x_r, prod_y_r;
  ray_t               ray6_r, ray6_nxt;
  ray_t               dly_r [DIV_STAGES];
  logic [16:0]        mag6_x, mag6_y, mag_x, mag_y;
  logic [23:0]        q_x, q_y;
  logic [23:0]        delta_x_nxt, delta_y_nxt;
  ray_t               ray12_r, ray13_r;
  logic [23:0]        delta_x12_r, delta_y12_r, delta_x13_r, delta_y13_r;
  logic [16:0]        span_x, span_y;
  logic [40:0]        side_x13_r, side_y13_r;
  logic signed [18:0] sum_x, sum_y;

  assign busy      = ~rst_n;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r <= '0;
      player_y_r <= '0;
      dir_x_r    <= 16'sd16384;
      dir_y_r    <= '0;
      pln_x_r    <= '0;
      pln_y_r    <= 16'sd10813;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PLAYER_X:    player_x_r <= cfg_data;
        REG_PLAYER_Y:    player_y_r <= cfg_data;
        REG_VIEW_DIR_X:  dir_x_r    <= cfg_data[15:0];
        REG_VIEW_DIR_Y:  dir_y_r    <= cfg_data[15:0];
        REG_CAM_PLANE_X: pln_x_r    <= cfg_data[15:0];
        REG_CAM_PLANE_Y: pln_y_r    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  rcs_camx #(.SCREEN_WIDTH(SCREEN_WIDTH)) u_camx (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start && !busy),
    .in_column (in_column),
    .cam_o     (cam)
  );

  // plane scaled by camera x
  always_ff @(posedge clk) begin
    prod_x_r <= 32'(pln_x_r) * 32'(cam.camx);
    prod_y_r <= 32'(pln_y_r) * 32'(cam.camx);
  end

  // dir + floor(prod / 2^14), clamped to q3.14
  always_comb begin
    sum_x = {{3{dir_x_r[15]}}, dir_x_r} + {prod_x_r[31], prod_x_r[31:14]};
    sum_y = {{3{dir_y_r[15]}}, dir_y_r} + {prod_y_r[31], prod_y_r[31:14]};
    ray6_nxt.valid = v5_r;
    if (sum_x < -19'sd65536) ray6_nxt.ray_x = -17'sd65536;
    else if (sum_x > 19'sd65535) ray6_nxt.ray_x = 17'sd65535;
    else ray6_nxt.ray_x = sum_x[16:0];
    if (sum_y < -19'sd65536) ray6_nxt.ray_y = -17'sd65536;
    else if (sum_y > 19'sd65535) ray6_nxt.ray_y = 17'sd65535;
    else ray6_nxt.ray_y = sum_y[16:0];
  end

  always_ff @(posedge clk) begin
    ray6_r.ray_x <= ray6_nxt.ray_x;
    ray6_r.ray_y <= ray6_nxt.ray_y;
  end

  assign mag6_x = ray6_r.ray_x[16] ? 17'(-ray6_r.ray_x) : ray6_r.ray_x;
  assign mag6_y = ray6_r.ray_y[16] ? 17'(-ray6_r.ray_y) : ray6_r.ray_y;

  rcs_recip u_recip_x (.clk(clk), .m_i(mag6_x), .q_o(q_x));
  rcs_recip u_recip_y (.clk(clk), .m_i(mag6_y), .q_o(q_y));

  // ray travels beside the divider
  always_ff @(posedge clk) begin
    dly_r[0].ray_x <= ray6_r.ray_x;
    dly_r[0].ray_y <= ray6_r.ray_y;
    for (int i = 1; i < DIV_STAGES; i++) begin
      dly_r[i].ray_x <= dly_r[i-1].ray_x;
      dly_r[i].ray_y <= dly_r[i-1].ray_y;
    end
  end

  assign mag_x = dly_r[DIV_STAGES-1].ray_x[16] ? 17'(-dly_r[DIV_STAGES-1].ray_x)
                                                : dly_r[DIV_STAGES-1].ray_x;
  assign mag_y = dly_r[DIV_STAGES-1].ray_y[16] ? 17'(-dly_r[DIV_STAGES-1].ray_y)
                                                : dly_r[DIV_STAGES-1].ray_y;

  always_comb begin
    if (dly_r[DIV_STAGES-1].ray_y == '0) delta_x_nxt = '0;
    else if (mag_x == '0) delta_x_nxt = ONE_Q14;
    else if (mag_x <= SAT_LIMIT) delta_x_nxt = DELTA_MAX;
    else delta_x_nxt = q_x;
    if (dly_r[DIV_STAGES-1].ray_x == '0) delta_y_nxt = '0;
    else if (mag_y == '0) delta_y_nxt = ONE_Q14;
    else if (mag_y <= SAT_LIMIT) delta_y_nxt = DELTA_MAX;
    else delta_y_nxt = q_y;
  end

  // fraction to the next cell boundary
  assign span_x = ray12_r.ray_x[16] ? {1'b0, player_x_r[15:0]}
                                    : 17'(17'h10000 - {1'b0, player_x_r[15:0]});
  assign span_y = ray12_r.ray_y[16] ? {1'b0, player_y_r[15:0]}
                                    : 17'(17'h10000 - {1'b0, player_y_r[15:0]});

  always_ff @(posedge clk) begin
    ray12_r.ray_x <= dly_r[DIV_STAGES-1].ray_x;
    ray12_r.ray_y <= dly_r[DIV_STAGES-1].ray_y;
    delta_x12_r   <= delta_x_nxt;
    delta_y12_r   <= delta_y_nxt;
    ray13_r.ray_x <= ray12_r.ray_x;
    ray13_r.ray_y <= ray12_r.ray_y;
    delta_x13_r   <= delta_x12_r;
    delta_y13_r   <= delta_y12_r;
    side_x13_r    <= 41'(span_x) * 41'(delta_x12_r);
    side_y13_r    <= 41'(span_y) * 41'(delta_y12_r);
    out_ray_x      <= ray13_r.ray_x;
    out_ray_y      <= ray13_r.ray_y;
    out_cell_x     <= player_x_r[21:16];
    out_cell_y     <= player_y_r[21:16];
    out_step_x_neg <= ray13_r.ray_x[16];
    out_step_y_neg <= ray13_r.ray_y[16];
    out_delta_x    <= delta_x13_r;
    out_delta_y    <= delta_y13_r;
    out_side_x     <= side_x13_r[39:16];
    out_side_y     <= side_y13_r[39:16];
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r          <= 1'b0;
      ray6_r.valid  <= 1'b0;
      for (int i = 0; i < DIV_STAGES; i++) dly_r[i].valid <= 1'b0;
      ray12_r.valid <= 1'b0;
      ray13_r.valid <= 1'b0;
      out_strobe    <= 1'b0;
    end else begin
      v5_r           <= cam.valid;
      ray6_r.valid   <= ray6_nxt.valid;
      dly_r[0].valid <= ray6_r.valid;
      for (int i = 1; i < DIV_STAGES; i++) dly_r[i].valid <= dly_r[i-1].valid;
      ray12_r.valid  <= dly_r[DIV_STAGES-1].valid;
      ray13_r.valid  <= ray12_r.valid;
      out_strobe     <= ray13_r.valid;
    end
  end

endmodule
`default_nettype wire

// File: sv/rcs_camx.sv
// camera x pipeline: 2*col*2^14/(width-1) - 2^14 by reciprocal multiply and correction
`default_nettype none
module rcs_camx #(
  parameter int SCREEN_WIDTH = 640
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic [11:0]  in_column,
  output rcs_pkg::cam_t     cam_o
);
  import rcs_pkg::*;

  localparam int          DIVISOR = SCREEN_WIDTH - 1;
  localparam logic [27:0] RECIP   = 28'((64'd1 << 27) / DIVISOR);
  localparam logic [11:0] DIV_L   = 12'(DIVISOR);

  logic        v1_r, v2_r, v3_r;
  logic [11:0] col1_r, col2_r, col3_r;
  logic [15:0] q2_r, q3_r;
  logic [27:0] prod3_r;
  cam_t        cam_r;

  logic [39:0] mul_full;
  logic [27:0] q0;
  logic [15:0] q0_nxt;
  logic [26:0] num;
  logic        ge;
  logic [16:0] q_fix;
  cam_t        cam_nxt;

  // estimate is the true quotient or one below it
  always_comb begin
    mul_full = 40'(col1_r) * 40'(RECIP);
    q0       = mul_full[39:12];
    q0_nxt   = (|q0[27:16]) ? 16'hFFFF : q0[15:0];
  end

  always_comb begin
    num   = {col3_r, 15'b0};
    ge    = {2'b0, num} >= ({1'b0, prod3_r} + {17'b0, DIV_L});
    q_fix = {1'b0, q3_r} + {16'b0, ge};
    cam_nxt.valid = v3_r;
    if (q_fix > 17'd49151) begin
      cam_nxt.camx = 16'sd32767;
    end else begin
      cam_nxt.camx = 16'(q_fix - 17'd16384);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      cam_r.valid <= 1'b0;
    end else begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      cam_r.valid <= cam_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    col1_r     <= in_column;
    col2_r     <= col1_r;
    q2_r       <= q0_nxt;
    col3_r     <= col2_r;
    q3_r       <= q2_r;
    prod3_r    <= 28'(q2_r) * 28'(DIV_L);
    cam_r.camx <= cam_nxt.camx;
  end

  assign cam_o = cam_r;

endmodule
`default_nettype wire

// File: sv/rcs_recip.sv
// pipelined restoring divider for the 2^28 / m reciprocal
`default_nettype none
module rcs_recip (
  input  wire logic        clk,
  input  wire logic [16:0] m_i,
  output logic      [23:0] q_o
);
  import rcs_pkg::*;

  logic [16:0] rem_r [DIV_STAGES-1];
  logic [16:0] m_r   [DIV_STAGES-1];
  logic [23:0] q_r   [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_st
    logic [16:0] rem_in, m_in, rem_nxt;
    logic [23:0] q_in, q_nxt;
    logic [17:0] t;

    if (s == 0) begin : g_first
      assign rem_in = REM_INIT;
      assign m_in   = m_i;
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign m_in   = m_r[s-1];
      assign q_in   = q_r[s-1];
    end

    always_comb begin
      rem_nxt = rem_in;
      q_nxt   = q_in;
      t       = '0;
      for (int k = 0; k < BITS_PER_STAGE; k++) begin
        t = {rem_nxt, 1'b0};
        if (t >= {1'b0, m_in}) begin
          rem_nxt = 17'(t - {1'b0, m_in});
          q_nxt   = {q_nxt[22:0], 1'b1};
        end else begin
          rem_nxt = t[16:0];
          q_nxt   = {q_nxt[22:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      q_r[s] <= q_nxt;
    end

    if (s < DIV_STAGES - 1) begin : g_keep
      always_ff @(posedge clk) begin
        rem_r[s] <= rem_nxt;
        m_r[s]   <= m_in;
      end
    end
  end

  assign q_o = q_r[DIV_STAGES-1];

endmodule
`default_nettype wire

// File: sv/rcs_checker.sv
// port level checks for the raycast column setup top level, with its bind
`default_nettype none
module rcs_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_strobe,
  input wire logic signed [16:0] out_ray_x,
  input wire logic signed [16:0] out_ray_y,
  input wire logic               out_step_x_neg,
  input wire logic [23:0]        out_delta_x,
  input wire logic [23:0]        out_side_x
);
  import rcs_pkg::*;

  // every accepted column yields a result a fixed time later
  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##PIPE_LATENCY out_strobe)
    else $error("accepted column produced no result");

  // no result without a column behind it
  a_result_has_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, PIPE_LATENCY))
    else $error("result without accepted column");

  a_step_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_step_x_neg == out_ray_x[16]))
    else $error("step x sign does not follow ray x");

  a_flat_ray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_ray_y == '0) |-> (out_delta_x == '0 && out_side_x == '0))
    else $error("zero ray y must give zero x delta and side");

  a_axis_ray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_ray_x == '0 && out_ray_y != '0) |-> (out_delta_x == ONE_Q14))
    else $error("zero ray x must give unit x delta");

endmodule

bind raycast_column_setup_top rcs_checker u_rcs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_ray_x      (out_ray_x),
  .out_ray_y      (out_ray_y),
  .out_step_x_neg (out_step_x_neg),
  .out_delta_x    (out_delta_x),
  .out_side_x     (out_side_x)
);
`default_nettype wire
